// ===== hdl/dcs_pkg.sv =====
// Shared package for the darkest circle selection block.
// Holds field widths, the sum limit, the controller state type and the pipeline tag.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dcs_pkg;

	localparam int DEF_MAX_CIRCLES = 8;
	localparam int DEF_COORD_BITS  = 10;

	localparam int SUM_W        = 28;
	localparam int VAL_W        = 8;
	localparam int SLOT_FIELD_W = 3;
	localparam int CNT_FIELD_W  = 4;

	localparam logic [SUM_W-1:0]       SUM_LIMIT = 28'd9999999;
	localparam logic [SUM_W-1:0]       SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [CNT_FIELD_W-1:0] CNT_RESET = 4'd1;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_PIXEL = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_RESULT
	} dcs_state_t;

	// Travels alongside each slot update through the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} dcs_tag_t;

endpackage
`default_nettype wire

// ===== hdl/dcs_ifs.sv =====
// Channel interfaces of the darkest circle selection block: request, result and
// configuration write. Depends on dcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dcs_req_if #(
	parameter int COORD_BITS = dcs_pkg::DEF_COORD_BITS
);
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [dcs_pkg::SLOT_FIELD_W-1:0]  circle_slot;
	logic [COORD_BITS-1:0]             circle_x;
	logic [COORD_BITS-1:0]             circle_y;
	logic [COORD_BITS-1:0]             circle_radius;
	logic [dcs_pkg::VAL_W-1:0]         pixel_value;
	logic [COORD_BITS-1:0]             pixel_col;
	logic [COORD_BITS-1:0]             pixel_row;
	logic                              last_pixel;

	modport source (
		output valid, req_type, circle_slot, circle_x, circle_y, circle_radius,
		       pixel_value, pixel_col, pixel_row, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, req_type, circle_slot, circle_x, circle_y, circle_radius,
		       pixel_value, pixel_col, pixel_row, last_pixel,
		output ready
	);
endinterface

interface dcs_res_if #(
	parameter int COORD_BITS = dcs_pkg::DEF_COORD_BITS
);
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [dcs_pkg::SLOT_FIELD_W-1:0]  best_slot;
	logic [COORD_BITS-1:0]             best_x;
	logic [COORD_BITS-1:0]             best_y;
	logic [COORD_BITS-1:0]             best_radius;
	logic [dcs_pkg::SUM_W-1:0]         best_sum;

	modport source (
		output valid, found, best_slot, best_x, best_y, best_radius, best_sum,
		input  ready
	);
	modport sink (
		input  valid, found, best_slot, best_x, best_y, best_radius, best_sum,
		output ready
	);
endinterface

interface dcs_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [dcs_pkg::CNT_FIELD_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/dcs_ram.sv =====
// Synchronous single-write, single-read memory with registered read.
// Per-entry valid bits make unwritten or cleared entries read as zero. Standalone.
`timescale 1ns / 1ps
`default_nettype none
module dcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	input  wire logic             clr_all,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr_all) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// ===== hdl/dcs_inside.sv =====
// Containment test and saturating accumulate for one circle slot per cycle.
// Two register stages: distance terms, then squares. Depends on dcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dcs_inside #(
	parameter int COORD_BITS = dcs_pkg::DEF_COORD_BITS,
	parameter int AW         = 3
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dcs_pkg::dcs_tag_t           tag_s1,
	input  wire logic [AW-1:0]               idx_s1,
	input  wire logic [3*COORD_BITS-1:0]     circ_s1,
	input  wire logic [dcs_pkg::SUM_W-1:0]   sum_s1,
	input  wire logic [COORD_BITS-1:0]       pix_col,
	input  wire logic [COORD_BITS-1:0]       pix_row,
	input  wire logic [dcs_pkg::VAL_W-1:0]   pix_val,
	output dcs_pkg::dcs_tag_t                tag_s3,
	output logic      [AW-1:0]               idx_s3,
	output logic      [3*COORD_BITS-1:0]     circ_s3,
	output logic      [dcs_pkg::SUM_W-1:0]   sum_new
);

	localparam int CB = COORD_BITS;
	localparam int SW = dcs_pkg::SUM_W;

	logic [CB-1:0] cx, cy, cr;
	logic [CB-1:0] dx, dy;

	dcs_pkg::dcs_tag_t tag_s2;
	logic [AW-1:0]     idx_s2;
	logic [3*CB-1:0]   circ_s2;
	logic [SW-1:0]     sum_s2, sum_s3;
	logic [CB-1:0]     dx_s2, dy_s2, r_s2;
	logic [2*CB-1:0]   dx2_s3, dy2_s3, r2_s3;

	logic [2*CB:0]     dist_sq;
	logic              in_circle;
	logic [SW:0]       acc;

	assign cx = circ_s1[3*CB-1:2*CB];
	assign cy = circ_s1[2*CB-1:CB];
	assign cr = circ_s1[CB-1:0];

	assign dx = (pix_col >= cx) ? pix_col - cx : cx - pix_col;
	assign dy = (pix_row >= cy) ? pix_row - cy : cy - pix_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		circ_s2 <= circ_s1;
		sum_s2  <= sum_s1;
		dx_s2   <= dx;
		dy_s2   <= dy;
		r_s2    <= cr;

		idx_s3  <= idx_s2;
		circ_s3 <= circ_s2;
		sum_s3  <= sum_s2;
		dx2_s3  <= {{CB{1'b0}}, dx_s2} * {{CB{1'b0}}, dx_s2};
		dy2_s3  <= {{CB{1'b0}}, dy_s2} * {{CB{1'b0}}, dy_s2};
		r2_s3   <= {{CB{1'b0}}, r_s2} * {{CB{1'b0}}, r_s2};
	end

	// Strictly inside when dx^2 + dy^2 < r^2; the sum saturates at all ones,
	// so a carry out of the add is exactly the overflow case.
	assign dist_sq   = {1'b0, dx2_s3} + {1'b0, dy2_s3};
	assign in_circle = dist_sq < {1'b0, r2_s3};
	assign acc       = {1'b0, sum_s3} + {{(SW + 1 - dcs_pkg::VAL_W){1'b0}}, pix_val};

	always_comb begin
		if (!in_circle) begin
			sum_new = sum_s3;
		end else if (acc[SW]) begin
			sum_new = dcs_pkg::SUM_MAX;
		end else begin
			sum_new = acc[SW-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/darkest_circle_select.sv =====
// Darkest circle selection: a load, or a pixel with no active slot, needs no pass
// over the slots; any other pixel starts one memory read per active slot, and the
// three-stage containment pipeline behind it drains before the next acceptance.
// A last pixel also passes the result state, which waits while the output register
// is full; its result enters the output register as the block returns to idle.
// Reset is asynchronous, active low; all slots read as zero and the count is 1.
`timescale 1ns / 1ps
`default_nettype none
module darkest_circle_select #(
	parameter int MAX_CIRCLES = dcs_pkg::DEF_MAX_CIRCLES,
	parameter int COORD_BITS  = dcs_pkg::DEF_COORD_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dcs_cfg_if.sink    cfg,
	dcs_req_if.sink    req,
	dcs_res_if.source  res
);

	// Slot address width and a counter wide enough to hold the slot count itself.
	localparam int AW     = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
	localparam int CNT_W  = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES + 1) : 1;
	localparam int CB     = COORD_BITS;
	localparam int CIRC_W = 3 * COORD_BITS;
	localparam int SW     = dcs_pkg::SUM_W;

	// ------------------------------------------------------------------
	// Configuration: the active slot count. Writes are always taken.
	// ------------------------------------------------------------------
	logic [dcs_pkg::CNT_FIELD_W-1:0] count_q;
	logic [CNT_W-1:0]                n_act;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= dcs_pkg::CNT_RESET;
		end else if (cfg.valid) begin
			count_q <= cfg.data;
		end
	end

	// A count above the number of slots means every slot.
	always_comb begin
		if (int'(count_q) > MAX_CIRCLES) begin
			n_act = CNT_W'(MAX_CIRCLES);
		end else begin
			n_act = CNT_W'(count_q);
		end
	end

	// ------------------------------------------------------------------
	// Controller. A pixel transaction starts a pass over the active slots:
	// one circle and one sum are read per cycle, updated in the pipeline and
	// written back from stage s3. Slots are distinct within a pass and
	// the next transaction is only taken once the last write-back is done,
	// so no forwarding is needed.
	// ------------------------------------------------------------------
	dcs_pkg::dcs_state_t state_q, state_d;

	logic req_acc, is_pixel, slot_ok, load_we;
	logic issue_en, last_issue, res_load;
	logic [AW-1:0]    load_addr;
	logic [AW-1:0]    idx_q;
	logic [CNT_W-1:0] n_q;
	logic             last_q;

	logic [dcs_pkg::VAL_W-1:0] pix_val_q;
	logic [CB-1:0]             pix_col_q, pix_row_q;

	dcs_pkg::dcs_tag_t tag_s1, tag_s3;
	logic [AW-1:0]     idx_s1, idx_s3;
	logic [CIRC_W-1:0] circ_s1, circ_s3;
	logic [SW-1:0]     sum_s1, sum_new;

	logic              res_valid_q;

	assign req_acc    = req.valid && req.ready;
	assign is_pixel   = (req.req_type == dcs_pkg::REQ_PIXEL);
	assign slot_ok    = int'(req.circle_slot) < MAX_CIRCLES;
	assign load_we    = req_acc && !is_pixel && slot_ok;
	assign load_addr  = AW'(req.circle_slot);
	assign last_issue = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dcs_pkg::ST_IDLE: begin
				if (req_acc && is_pixel) begin
					if (n_act != '0) begin
						state_d = dcs_pkg::ST_ISSUE;
					end else if (req.last_pixel) begin
						state_d = dcs_pkg::ST_RESULT;
					end
				end
			end
			dcs_pkg::ST_ISSUE: begin
				if (last_issue) begin
					state_d = dcs_pkg::ST_DRAIN;
				end
			end
			dcs_pkg::ST_DRAIN: begin
				if (tag_s3.valid && tag_s3.last) begin
					state_d = last_q ? dcs_pkg::ST_RESULT : dcs_pkg::ST_IDLE;
				end
			end
			dcs_pkg::ST_RESULT: begin
				if (res_load) begin
					state_d = dcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dcs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		issue_en  = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			dcs_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			dcs_pkg::ST_ISSUE: begin
				issue_en = 1'b1;
			end
			dcs_pkg::ST_DRAIN: begin
			end
			dcs_pkg::ST_RESULT: begin
				// The output register frees up when its transaction completes.
				res_load = !res_valid_q || res.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcs_pkg::ST_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
			last_q  <= 1'b0;
			tag_s1  <= '0;
		end else begin
			state_q      <= state_d;
			tag_s1.valid <= issue_en;
			tag_s1.last  <= issue_en && last_issue;
			if (req_acc && is_pixel) begin
				idx_q  <= '0;
				n_q    <= n_act;
				last_q <= req.last_pixel;
			end else if (issue_en) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (req_acc && is_pixel) begin
			pix_val_q <= req.pixel_value;
			pix_col_q <= req.pixel_col;
			pix_row_q <= req.pixel_row;
		end
	end

	// ------------------------------------------------------------------
	// State memories. A load writes the circle and zeroes its sum; the
	// result clears every sum at once through the valid bits.
	// ------------------------------------------------------------------
	dcs_ram #(
		.WIDTH (CIRC_W),
		.DEPTH (MAX_CIRCLES),
		.AW    (AW)
	) u_circle_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_we),
		.wr_addr (load_addr),
		.wr_data ({req.circle_x, req.circle_y, req.circle_radius}),
		.rd_en   (issue_en),
		.rd_addr (idx_q),
		.clr_all (1'b0),
		.rd_data (circ_s1)
	);

	dcs_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_CIRCLES),
		.AW    (AW)
	) u_sum_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_we || tag_s3.valid),
		.wr_addr (tag_s3.valid ? idx_s3 : load_addr),
		.wr_data (tag_s3.valid ? sum_new : '0),
		.rd_en   (issue_en),
		.rd_addr (idx_q),
		.clr_all (res_load),
		.rd_data (sum_s1)
	);

	dcs_inside #(
		.COORD_BITS (COORD_BITS),
		.AW         (AW)
	) u_inside (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.idx_s1  (idx_s1),
		.circ_s1 (circ_s1),
		.sum_s1  (sum_s1),
		.pix_col (pix_col_q),
		.pix_row (pix_row_q),
		.pix_val (pix_val_q),
		.tag_s3  (tag_s3),
		.idx_s3  (idx_s3),
		.circ_s3 (circ_s3),
		.sum_new (sum_new)
	);

	// ------------------------------------------------------------------
	// Running minimum. Updated sums arrive in ascending slot order, so a
	// strict compare keeps the lowest slot on ties. Starting at the limit
	// means only sums below it can be chosen.
	// ------------------------------------------------------------------
	logic              found_q;
	logic [SW-1:0]     best_sum_q;
	logic [AW-1:0]     best_idx_q;
	logic [CIRC_W-1:0] best_circ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			best_sum_q  <= dcs_pkg::SUM_LIMIT;
			best_idx_q  <= '0;
			best_circ_q <= '0;
		end else if (req_acc && is_pixel) begin
			found_q     <= 1'b0;
			best_sum_q  <= dcs_pkg::SUM_LIMIT;
			best_idx_q  <= '0;
			best_circ_q <= '0;
		end else if (tag_s3.valid && (sum_new < best_sum_q)) begin
			found_q     <= 1'b1;
			best_sum_q  <= sum_new;
			best_idx_q  <= idx_s3;
			best_circ_q <= circ_s3;
		end
	end

	// ------------------------------------------------------------------
	// Output register. It holds a finished result until its transaction
	// completes; a nothing-found result carries zeros in every field.
	// ------------------------------------------------------------------
	logic                               res_found_q;
	logic [dcs_pkg::SLOT_FIELD_W-1:0]   res_slot_q;
	logic [CIRC_W-1:0]                  res_circ_q;
	logic [SW-1:0]                      res_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_found_q <= found_q;
			res_slot_q  <= dcs_pkg::SLOT_FIELD_W'(best_idx_q);
			res_circ_q  <= best_circ_q;
			res_sum_q   <= found_q ? best_sum_q : '0;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.found       = res_found_q;
	assign res.best_slot   = res_slot_q;
	assign res.best_x      = res_circ_q[3*CB-1:2*CB];
	assign res.best_y      = res_circ_q[2*CB-1:CB];
	assign res.best_radius = res_circ_q[CB-1:0];
	assign res.best_sum    = res_sum_q;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for darkest_circle_select: directed and random circle loads and
// pixel images, checked against a cycle-free model of the darkest circle choice.
// Depends on dcs_pkg and the channel interfaces in dcs_ifs.sv.
`timescale 1ns / 1ps
module tb_top;

	localparam int NSLOT  = dcs_pkg::DEF_MAX_CIRCLES;
	localparam int CW     = dcs_pkg::DEF_COORD_BITS;
	localparam int VW     = dcs_pkg::VAL_W;
	localparam int SUMW   = dcs_pkg::SUM_W;
	localparam int CNTW   = dcs_pkg::CNT_FIELD_W;
	// Quiet cycles after the last result before a count write or the end of the run.
	// This covers any pixel still in flight, including the result state of a last pixel.
	localparam int SETTLE = 2 * NSLOT + 8;
	localparam int RANDOM_REQS = 1500;

	// One request as the sender presents it.
	typedef struct packed {
		dcs_pkg::req_kind_t kind;
		logic [2:0]      slot;
		logic [CW-1:0]   cx;
		logic [CW-1:0]   cy;
		logic [CW-1:0]   cr;
		logic [VW-1:0]   value;
		logic [CW-1:0]   col;
		logic [CW-1:0]   row;
		logic            last;
	} scan_req_t;

	// One selection outcome, the way the result channel carries it.
	typedef struct packed {
		logic             found;
		logic [2:0]       slot;
		logic [CW-1:0]    x;
		logic [CW-1:0]    y;
		logic [CW-1:0]    r;
		logic [SUMW-1:0]  sum;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dcs_cfg_if             cfg_ch ();
	dcs_req_if #(.COORD_BITS(CW)) req_ch ();
	dcs_res_if #(.COORD_BITS(CW)) res_ch ();

	darkest_circle_select #(
		.MAX_CIRCLES(NSLOT),
		.COORD_BITS(CW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.res(res_ch)
	);

	// 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Model of the block. It holds its own copy of the circle table, the
	// running sums inside each circle and the active circle count. The count
	// is only changed when a configuration transaction completes, and the
	// table and sums only when a request transaction completes, so the model
	// follows the block's order of events exactly.
	// ------------------------------------------------------------------
	logic [CW-1:0]    disc_x   [NSLOT];
	logic [CW-1:0]    disc_y   [NSLOT];
	logic [CW-1:0]    disc_r   [NSLOT];
	logic [SUMW-1:0]  disc_sum [NSLOT];
	logic [CNTW-1:0]  active_count = dcs_pkg::CNT_RESET;

	pick_t     wanted_picks [$];  // selections still owed by the block, oldest first
	scan_req_t todo_reqs    [$];  // requests waiting for the sender

	int errors        = 0;
	int reqs_sent     = 0;
	int reqs_queued   = 0;
	int picks_checked = 0;
	int picks_empty   = 0;
	int count_writes  = 0;
	bit no_idle       = 1'b0;

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			disc_x[i]   = '0;
			disc_y[i]   = '0;
			disc_r[i]   = '0;
			disc_sum[i] = '0;
		end
	end

	// Applies one accepted request to the model. A load replaces a circle and
	// clears its sum. A pixel adds its value to the sum of every active circle
	// that holds it strictly inside, saturating at the top of the sum range.
	// On the last pixel the darkest circle below the limit is chosen, lowest
	// slot first on ties, and all sums start over.
	function automatic void apply_request(input scan_req_t rq);
		int unsigned n;
		int unsigned dx;
		int unsigned dy;
		int unsigned rr;
		logic [SUMW:0]   grown;
		logic [SUMW-1:0] low;
		pick_t pk;
		n = (active_count > NSLOT) ? NSLOT : active_count;
		if (rq.kind == dcs_pkg::REQ_LOAD) begin
			if (rq.slot < NSLOT) begin
				disc_x[rq.slot]   = rq.cx;
				disc_y[rq.slot]   = rq.cy;
				disc_r[rq.slot]   = rq.cr;
				disc_sum[rq.slot] = '0;
			end
			return;
		end
		for (int i = 0; i < n; i++) begin
			dx = (rq.col >= disc_x[i]) ? rq.col - disc_x[i] : disc_x[i] - rq.col;
			dy = (rq.row >= disc_y[i]) ? rq.row - disc_y[i] : disc_y[i] - rq.row;
			rr = disc_r[i];
			if (dx * dx + dy * dy < rr * rr) begin
				grown = disc_sum[i] + rq.value;
				disc_sum[i] = (grown > dcs_pkg::SUM_MAX) ? dcs_pkg::SUM_MAX : grown[SUMW-1:0];
			end
		end
		if (!rq.last)
			return;
		pk  = '0;
		low = dcs_pkg::SUM_LIMIT;
		for (int i = 0; i < n; i++) begin
			if (disc_sum[i] < low) begin
				low      = disc_sum[i];
				pk.found = 1'b1;
				pk.slot  = 3'(i);
			end
		end
		// When nothing qualifies, every field of the result stays zero.
		if (pk.found) begin
			pk.x   = disc_x[pk.slot];
			pk.y   = disc_y[pk.slot];
			pk.r   = disc_r[pk.slot];
			pk.sum = low;
		end
		wanted_picks = {wanted_picks, pk};
		for (int i = 0; i < NSLOT; i++)
			disc_sum[i] = '0;
	endfunction

	// ------------------------------------------------------------------
	// Request driver. Handshakes are sampled at the rising edge, where an
	// accepted transaction goes into the model; new values are driven at
	// the falling edge. Each cycle the sender may idle at random unless a
	// no-idle stretch is running.
	// ------------------------------------------------------------------
	scan_req_t req_now;
	bit        req_took = 1'b0;

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			apply_request(req_now);
			req_took = 1'b1;
			reqs_sent++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_took)) begin
			req_took = 1'b0;
			if (todo_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 35)) begin
				req_now = todo_reqs.pop_front();
				req_ch.valid         <= 1'b1;
				req_ch.req_type      <= req_now.kind;
				req_ch.circle_slot   <= req_now.slot;
				req_ch.circle_x      <= req_now.cx;
				req_ch.circle_y      <= req_now.cy;
				req_ch.circle_radius <= req_now.cr;
				req_ch.pixel_value   <= req_now.value;
				req_ch.pixel_col     <= req_now.col;
				req_ch.pixel_row     <= req_now.row;
				req_ch.last_pixel    <= req_now.last;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// The receiver stalls at random as well, outside no-idle stretches.
	always @(negedge clk) begin
		res_ch.ready <= no_idle || ($urandom_range(99) >= 35);
	end

	// ------------------------------------------------------------------
	// Result monitor: every completed result transaction is compared field
	// by field with the oldest selection the model still owes.
	// ------------------------------------------------------------------
	task automatic check_field(input string what, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	pick_t pick_due;

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (wanted_picks.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual found=%0d slot=%0d sum=%0d",
					$time, res_ch.found, res_ch.best_slot, res_ch.best_sum);
				errors++;
			end else begin
				pick_due = wanted_picks.pop_front();
				check_field("found", pick_due.found, res_ch.found);
				check_field("best_slot", pick_due.slot, res_ch.best_slot);
				check_field("best_x", pick_due.x, res_ch.best_x);
				check_field("best_y", pick_due.y, res_ch.best_y);
				check_field("best_radius", pick_due.r, res_ch.best_radius);
				check_field("best_sum", pick_due.sum, res_ch.best_sum);
				picks_checked++;
				if (!pick_due.found)
					picks_empty++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers. They only fill the request queue; the driver above
	// decides when each request goes out.
	// ------------------------------------------------------------------
	int aim_x [NSLOT];
	int aim_y [NSLOT];
	int aim_r [NSLOT];

	task automatic queue_load(input int slot, input int x, input int y, input int r,
		input bit last);
		scan_req_t rq;
		rq       = '0;
		rq.kind  = dcs_pkg::REQ_LOAD;
		rq.slot  = 3'(slot);
		rq.cx    = CW'(x);
		rq.cy    = CW'(y);
		rq.cr    = CW'(r);
		// Pixel fields carry junk on a load; the block must ignore them.
		rq.value = VW'($urandom);
		rq.col   = CW'($urandom);
		rq.row   = CW'($urandom);
		rq.last  = last;
		todo_reqs = {todo_reqs, rq};
		reqs_queued++;
	endtask

	task automatic queue_pixel(input int value, input int col, input int row, input bit last);
		scan_req_t rq;
		rq       = '0;
		rq.kind  = dcs_pkg::REQ_PIXEL;
		rq.slot  = 3'($urandom);
		rq.cx    = CW'($urandom);
		rq.cy    = CW'($urandom);
		rq.cr    = CW'($urandom);
		rq.value = VW'(value);
		rq.col   = CW'(col);
		rq.row   = CW'(row);
		rq.last  = last;
		todo_reqs = {todo_reqs, rq};
		reqs_queued++;
	endtask

	// Radii are mostly small so pixels land both inside and outside, with an
	// occasional wide one up to the full coordinate range.
	task automatic queue_random_load();
		int slot;
		int r;
		int pick;
		slot = $urandom_range(NSLOT - 1);
		pick = $urandom_range(99);
		if (pick < 80)
			r = $urandom_range(30);
		else if (pick < 95)
			r = $urandom_range(200, 30);
		else
			r = $urandom_range((1 << CW) - 1);
		aim_x[slot] = $urandom_range((1 << CW) - 1);
		aim_y[slot] = $urandom_range((1 << CW) - 1);
		aim_r[slot] = r;
		queue_load(slot, aim_x[slot], aim_y[slot], r, $urandom_range(1));
	endtask

	// A well-formed image: a few loads, then pixels mostly aimed near a
	// loaded circle and closed by a last pixel. Noise is mixed in: pixels
	// anywhere, loads in the middle of the stream, and an early last flag now
	// and then.
	task automatic queue_random_image();
		int n_loads;
		int n_pix;
		int slot;
		int span;
		int col;
		int row;
		bit last;
		n_loads = $urandom_range(4);
		for (int k = 0; k < n_loads; k++)
			queue_random_load();
		n_pix = $urandom_range(30, 3);
		for (int k = 0; k < n_pix; k++) begin
			if ($urandom_range(99) < 4)
				queue_random_load();
			if ($urandom_range(99) < 80) begin
				slot = $urandom_range(NSLOT - 1);
				span = ((aim_r[slot] < 60) ? aim_r[slot] : 60) + 2;
				col  = aim_x[slot] + int'($urandom_range(2 * span)) - span;
				row  = aim_y[slot] + int'($urandom_range(2 * span)) - span;
			end else begin
				col = $urandom_range((1 << CW) - 1);
				row = $urandom_range((1 << CW) - 1);
			end
			last = (k == n_pix - 1) || ($urandom_range(99) < 2);
			queue_pixel($urandom_range(255), col & ((1 << CW) - 1), row & ((1 << CW) - 1), last);
		end
	endtask

	// Holds off until the sender has nothing left, every owed result has
	// arrived, and any pixel still inside the block has had time to finish.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (todo_reqs.size() != 0 || req_ch.valid || wanted_picks.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes the circle count; only called while the block is idle.
	task automatic write_count(input int value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= CNTW'(value);
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		active_count = CNTW'(value);
		count_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		int base;
		int sel;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = dcs_pkg::REQ_LOAD;
		req_ch.circle_slot   = '0;
		req_ch.circle_x      = '0;
		req_ch.circle_y      = '0;
		req_ch.circle_radius = '0;
		req_ch.pixel_value   = '0;
		req_ch.pixel_col     = '0;
		req_ch.pixel_row     = '0;
		req_ch.last_pixel    = 1'b0;
		res_ch.ready         = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.data          = '0;
		for (int i = 0; i < NSLOT; i++) begin
			aim_x[i] = 0;
			aim_y[i] = 0;
			aim_r[i] = 0;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// All eight slots active. Circles sit at the corners and the middle
		// of the coordinate range, one has radius zero, two are identical,
		// and a load carries a last flag that must be ignored. A pixel lands
		// exactly on a circle's edge and must not count. Unloaded and empty
		// circles keep a zero sum, so the lowest such slot wins the tie.
		write_count(NSLOT);
		queue_load(0, 0, 0, (1 << CW) - 1, 1'b0);
		queue_load(NSLOT - 1, (1 << CW) - 1, (1 << CW) - 1, (1 << CW) - 1, 1'b1);
		queue_load(1, 512, 512, 0, 1'b0);
		queue_load(2, 5, 5, 3, 1'b0);
		queue_load(3, 5, 5, 3, 1'b0);
		queue_pixel(255, 0, 0, 1'b0);
		queue_pixel(0, (1 << CW) - 1, (1 << CW) - 1, 1'b0);
		queue_pixel(200, 5, 5, 1'b0);
		queue_pixel(77, 8, 5, 1'b0);
		queue_pixel(1, 6, 6, 1'b1);
		wait_idle();

		// No active slot at all: the last pixel reports nothing found.
		write_count(0);
		queue_pixel(9, 5, 5, 1'b1);
		wait_idle();

		// A count above the slot total behaves as the slot total.
		write_count((1 << CNTW) - 1);
		queue_pixel(50, 1000, 1000, 1'b1);
		wait_idle();

		// Four slots with nonzero sums. A reload in the middle of the image
		// clears that slot's sum, and the two identical circles tie for the
		// darkest, which must go to the lower slot.
		write_count(4);
		queue_load(0, 100, 100, 50, 1'b0);
		queue_load(1, 5, 5, 3, 1'b0);
		queue_pixel(10, 5, 5, 1'b0);
		queue_pixel(20, 100, 100, 1'b0);
		queue_load(3, 1000, 1000, 2, 1'b0);
		queue_pixel(20, 1000, 1001, 1'b0);
		queue_pixel(4, 5, 6, 1'b1);
		wait_idle();

		// A stretch with no idling on either side, so requests and results
		// follow each other as fast as the block allows.
		write_count(NSLOT);
		no_idle = 1'b1;
		for (int k = 0; k < 6; k++)
			queue_random_image();
		wait_idle();
		no_idle = 1'b0;

		// Random phases: each picks a count, extremes weighted, runs a few
		// images and drains fully before the next count is written.
		base = reqs_queued;
		while (reqs_queued - base < RANDOM_REQS) begin
			sel = $urandom_range(7);
			case (sel)
				0: write_count(0);
				1: write_count(1);
				2: write_count(NSLOT);
				3: write_count((1 << CNTW) - 1);
				default: write_count($urandom_range((1 << CNTW) - 1));
			endcase
			sel = $urandom_range(4, 1);
			for (int k = 0; k < sel; k++)
				queue_random_image();
			wait_idle();
		end

		$display("Sent %0d requests over %0d circle count settings.", reqs_sent, count_writes);
		$display("Checked %0d selections, %0d of them with no circle below the limit.",
			picks_checked, picks_empty);
		if (errors == 0 && wanted_picks.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Guard against a hung handshake; far above the longest correct run.
	initial begin
		#20_000_000;
		$display("Timeout with %0d results still owed.", wanted_picks.size());
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== darkest_circle_select.f =====
hdl/dcs_pkg.sv
hdl/dcs_ifs.sv
hdl/dcs_ram.sv
hdl/dcs_inside.sv
hdl/darkest_circle_select.sv
sim/tb_top.sv
